// File: rtl/assert_macros.svh
// Assertion helpers included by the codec top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, switched off while reset is held.
`define ASSERT_CLK(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, switched off while reset is held.
`define ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/rtcdtc_pkg.sv
`timescale 1ns / 1ps

package rtcdtc_pkg;

    localparam int IN_DATA_W  = 112;
    localparam int OUT_DATA_W = 96;
    localparam int IMG_W      = 56;

    localparam logic [15:0] YEAR_BASE = 16'd2000;
    localparam logic [15:0] YEAR_LAST = 16'd2099;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_INTEGRITY = 2'd1,
        STATUS_INVALID   = 2'd2
    } status_t;

    // Packed BCD byte to binary, each nibble taken at face value.
    function automatic logic [7:0] from_bcd(input logic [7:0] v);
        logic [7:0] hi;
        hi = {4'd0, v[7:4]};
        return (hi << 3) + (hi << 1) + {4'd0, v[3:0]};
    endfunction

    // Binary 0..99 to packed BCD; tens by reciprocal multiply (205 / 2048).
    function automatic logic [7:0] to_bcd(input logic [6:0] v);
        logic [14:0] prod;
        logic [3:0]  tens;
        logic [6:0]  rem;
        prod = 15'(v) * 15'd205;
        tens = prod[14:11];
        rem  = v - ((7'(tens) << 3) + (7'(tens) << 1));
        return {tens, rem[3:0]};
    endfunction

    function automatic logic [4:0] month_days(input logic [3:0] mo, input logic leap);
        logic [4:0] len;
        case (mo) inside
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                   len = 5'd30;
            4'd2:                                       len = leap ? 5'd29 : 5'd28;
            default:                                    len = 5'd0;
        endcase
        return len;
    endfunction

    // Weekday offset of each month for the Sakamoto method.
    function automatic logic [2:0] dow_offset(input logic [3:0] mo);
        logic [2:0] off;
        case (mo)
            4'd1:    off = 3'd0;
            4'd2:    off = 3'd3;
            4'd3:    off = 3'd2;
            4'd4:    off = 3'd5;
            4'd5:    off = 3'd0;
            4'd6:    off = 3'd3;
            4'd7:    off = 3'd5;
            4'd8:    off = 3'd1;
            4'd9:    off = 3'd4;
            4'd10:   off = 3'd6;
            4'd11:   off = 3'd2;
            4'd12:   off = 3'd4;
            default: off = 3'd0;
        endcase
        return off;
    endfunction

    // Remainder by seven of an 8-bit value: octal digits fold because 8 is 1 mod 7.
    function automatic logic [2:0] mod7(input logic [7:0] v);
        logic [4:0] s1;
        logic [3:0] s2;
        s1 = 5'(v[7:6]) + 5'(v[5:3]) + 5'(v[2:0]);
        s2 = 4'(s1[4:3]) + 4'(s1[2:0]);
        return (s2 >= 4'd7) ? 3'(s2 - 4'd7) : s2[2:0];
    endfunction

endpackage

// File: rtl/rtc_datetime_register_codec_top.sv
`timescale 1ns / 1ps
// Real-time clock date-time codec.
// The slave channel takes one word per transfer: s_tuser selects encode (0) or decode (1),
// s_tdata carries the binary date-time and a seven-byte register image. Encode checks the
// date-time, works out the weekday and packs the BCD register image; decode strips the
// control bits from each date and time byte, converts it from BCD and checks the result.
// The master channel returns exactly one word per accepted word, in order: m_tuser holds
// the status and m_tdata the decoded fields and the encoded image. On any failure every
// field but the status is zero.
// A word passes three register stages: decode and range checks, month length plus BCD
// packing plus the weekday sum, and the weekday remainder with the final zeroing. m_tvalid
// rises once the word has reached the third stage register.
// A new word may be accepted every cycle while m_tready stays high.
// When the receiver stalls, each stage holds its word and empty stages ahead of a stalled
// stage still fill, so up to three words are held before s_tready drops; nothing is lost
// or repeated. s_tready is combinational from m_tready through the stage valid bits.
// Reset (aresetn low at a clock edge) empties all three stages; the block keeps no
// other state, so there is no set-up phase after reset.
module rtc_datetime_register_codec_top (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // [15:0] year, [23:16] month, [31:24] day, [39:32] hour, [47:40] minute,
    // [55:48] second, [111:56] register_image_in
    input  logic [111:0] s_tdata,
    // [0] action
    input  logic [0:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // [11:0] year_out, [15:12] month_out, [20:16] day_out, [25:21] hour_out,
    // [31:26] minute_out, [37:32] second_out, [93:38] register_image_out, [95:94] zero
    output logic [95:0]  m_tdata,
    // [1:0] status
    output logic [1:0]   m_tuser
);

    // ---------------------------------------------------------------------
    // Handshake: a stage takes a word when it is empty or its word moves on.
    // ---------------------------------------------------------------------
    logic a_valid_reg, b_valid_reg, c_valid_reg;
    logic a_ready, b_ready, c_ready;

    assign c_ready  = !c_valid_reg || m_tready;
    assign b_ready  = !b_valid_reg || c_ready;
    assign a_ready  = !a_valid_reg || b_ready;
    assign s_tready = a_ready;

    // ---------------------------------------------------------------------
    // Stage A: pick encode or decode fields, convert from BCD, range checks.
    // ---------------------------------------------------------------------
    logic [rtcdtc_pkg::IMG_W-1:0] img_in;
    logic [15:0] year_in;
    logic        enc;
    logic [7:0]  dec_s, dec_mi, dec_h, dec_d, dec_mo, dec_y;
    logic [7:0]  sel_s, sel_mi, sel_h, sel_d, sel_mo;
    logic [15:0] year_off;
    logic [6:0]  sel_yy;
    logic        year_ok;

    assign img_in  = s_tdata[111:56];
    assign year_in = s_tdata[15:0];
    assign enc     = !s_tuser[0];

    assign dec_s  = rtcdtc_pkg::from_bcd({1'b0, img_in[6:0]});
    assign dec_mi = rtcdtc_pkg::from_bcd({1'b0, img_in[14:8]});
    assign dec_h  = rtcdtc_pkg::from_bcd({2'b0, img_in[21:16]});
    assign dec_d  = rtcdtc_pkg::from_bcd({2'b0, img_in[29:24]});
    assign dec_mo = rtcdtc_pkg::from_bcd({3'b0, img_in[44:40]});
    assign dec_y  = rtcdtc_pkg::from_bcd(img_in[55:48]);

    assign year_off = year_in - rtcdtc_pkg::YEAR_BASE;

    always_comb begin
        if (enc) begin
            sel_s   = s_tdata[55:48];
            sel_mi  = s_tdata[47:40];
            sel_h   = s_tdata[39:32];
            sel_d   = s_tdata[31:24];
            sel_mo  = s_tdata[23:16];
            sel_yy  = year_off[6:0];
            year_ok = (year_in >= rtcdtc_pkg::YEAR_BASE) && (year_in <= rtcdtc_pkg::YEAR_LAST);
        end else begin
            sel_s   = dec_s;
            sel_mi  = dec_mi;
            sel_h   = dec_h;
            sel_d   = dec_d;
            sel_mo  = dec_mo;
            sel_yy  = dec_y[6:0];
            year_ok = (dec_y <= 8'd99);
        end
    end

    logic       a_enc_reg, a_integ_reg, a_range_ok_reg;
    logic [6:0] a_yy_reg;
    logic [3:0] a_mo_reg;
    logic [4:0] a_d_reg, a_h_reg;
    logic [5:0] a_mi_reg, a_s_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (a_ready) begin
            a_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (a_ready && s_tvalid) begin
            a_enc_reg      <= enc;
            a_integ_reg    <= !enc && img_in[7];
            a_range_ok_reg <= year_ok && (sel_mo >= 8'd1) && (sel_mo <= 8'd12) &&
                              (sel_d >= 8'd1) && (sel_d <= 8'd31) &&
                              (sel_h < 8'd24) && (sel_mi < 8'd60) && (sel_s < 8'd60);
            a_yy_reg       <= sel_yy;
            a_mo_reg       <= sel_mo[3:0];
            a_d_reg        <= sel_d[4:0];
            a_h_reg        <= sel_h[4:0];
            a_mi_reg       <= sel_mi[5:0];
            a_s_reg        <= sel_s[5:0];
        end
    end

    // ---------------------------------------------------------------------
    // Stage B: month length check, BCD packing and the weekday sum.
    // The years checked are 2000 to 2099, so a year is a leap year exactly when
    // it divides by four. In the Sakamoto sum the constant part for a year of
    // 2000 + b is 2485 + b + b/4, and 2485 is a multiple of seven; January and
    // February of 2000 count against 1999, which leaves five.
    // ---------------------------------------------------------------------
    logic       early;
    logic [6:0] wk_year;
    logic [7:0] wk_sum;
    logic       day_ok;

    assign early   = (a_mo_reg < 4'd3);
    assign wk_year = a_yy_reg - 7'(early);
    assign day_ok  = (a_d_reg <= rtcdtc_pkg::month_days(a_mo_reg, (a_yy_reg[1:0] == 2'd0)));

    always_comb begin
        if (early && (a_yy_reg == 7'd0)) begin
            wk_sum = 8'd5 + 8'(rtcdtc_pkg::dow_offset(a_mo_reg)) + 8'(a_d_reg);
        end else begin
            wk_sum = 8'(wk_year) + 8'(wk_year[6:2]) +
                     8'(rtcdtc_pkg::dow_offset(a_mo_reg)) + 8'(a_d_reg);
        end
    end

    logic       b_enc_reg, b_integ_reg, b_ok_reg;
    logic [6:0] b_yy_reg;
    logic [3:0] b_mo_reg;
    logic [4:0] b_d_reg, b_h_reg;
    logic [5:0] b_mi_reg, b_s_reg;
    logic [7:0] b_bcd_s_reg, b_bcd_mi_reg, b_bcd_h_reg, b_bcd_d_reg;
    logic [7:0] b_bcd_mo_reg, b_bcd_yy_reg, b_wk_sum_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else if (b_ready) begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (b_ready && a_valid_reg) begin
            b_enc_reg    <= a_enc_reg;
            b_integ_reg  <= a_integ_reg;
            b_ok_reg     <= a_range_ok_reg && day_ok;
            b_yy_reg     <= a_yy_reg;
            b_mo_reg     <= a_mo_reg;
            b_d_reg      <= a_d_reg;
            b_h_reg      <= a_h_reg;
            b_mi_reg     <= a_mi_reg;
            b_s_reg      <= a_s_reg;
            b_bcd_s_reg  <= rtcdtc_pkg::to_bcd({1'b0, a_s_reg});
            b_bcd_mi_reg <= rtcdtc_pkg::to_bcd({1'b0, a_mi_reg});
            b_bcd_h_reg  <= rtcdtc_pkg::to_bcd({2'b0, a_h_reg});
            b_bcd_d_reg  <= rtcdtc_pkg::to_bcd({2'b0, a_d_reg});
            b_bcd_mo_reg <= rtcdtc_pkg::to_bcd({3'b0, a_mo_reg});
            b_bcd_yy_reg <= rtcdtc_pkg::to_bcd(a_yy_reg);
            b_wk_sum_reg <= wk_sum;
        end
    end

    // ---------------------------------------------------------------------
    // Stage C: weekday remainder, status and zeroing of the unused fields.
    // ---------------------------------------------------------------------
    rtcdtc_pkg::status_t        status_next;
    logic [11:0]                year_out_next;
    logic [rtcdtc_pkg::IMG_W-1:0] image_next;
    logic [rtcdtc_pkg::OUT_DATA_W-1:0] data_next;

    assign year_out_next = 12'(rtcdtc_pkg::YEAR_BASE) + 12'(b_yy_reg);

    always_comb begin
        data_next  = '0;
        image_next = {b_bcd_yy_reg, b_bcd_mo_reg, 5'd0, rtcdtc_pkg::mod7(b_wk_sum_reg),
                      b_bcd_d_reg, b_bcd_h_reg, b_bcd_mi_reg, b_bcd_s_reg};
        if (b_integ_reg) begin
            status_next = rtcdtc_pkg::STATUS_INTEGRITY;
        end else if (!b_ok_reg) begin
            status_next = rtcdtc_pkg::STATUS_INVALID;
        end else begin
            status_next = rtcdtc_pkg::STATUS_OK;
            if (b_enc_reg) begin
                data_next[93:38] = image_next;
            end else begin
                data_next[11:0]  = year_out_next;
                data_next[15:12] = b_mo_reg;
                data_next[20:16] = b_d_reg;
                data_next[25:21] = b_h_reg;
                data_next[31:26] = b_mi_reg;
                data_next[37:32] = b_s_reg;
            end
        end
    end

    logic [rtcdtc_pkg::OUT_DATA_W-1:0] c_data_reg;
    logic [1:0]                        c_status_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_valid_reg <= 1'b0;
        end else if (c_ready) begin
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (c_ready && b_valid_reg) begin
            c_data_reg   <= data_next;
            c_status_reg <= status_next;
        end
    end

    assign m_tvalid = c_valid_reg;
    assign m_tdata  = c_data_reg;
    assign m_tuser  = c_status_reg;

    // ---------------------------------------------------------------------
    // Checks
    // ---------------------------------------------------------------------
`include "assert_macros.svh"

    `ASSERT_CLK(a_fail_zero, aclk, aresetn, m_tvalid && (m_tuser != rtcdtc_pkg::STATUS_OK), m_tdata == '0, "failed word carries non-zero data")
    `ASSERT_CLK(a_empty_ready, aclk, aresetn, !m_tvalid, s_tready, "input stalled while the output stage is empty")
    `ASSERT_CLK(a_weekday_range, aclk, aresetn, m_tvalid && (m_tuser == rtcdtc_pkg::STATUS_OK), m_tdata[72:70] < 3'd7, "weekday out of range")
    `ASSERT_NEXT(a_mid_hold, aclk, aresetn, b_valid_reg && !c_ready, b_valid_reg, "middle stage dropped a stalled word")

endmodule
